/* rtl/boxavg_pkg.sv */
// ----------------------------------------------------------------------------
// boxavg_pkg
// Shared constants and types of the multichannel boxcar average core.
// ----------------------------------------------------------------------------
package boxavg_pkg;

  localparam int NUM_CH     = 8;
  localparam int FIELD_BITS = 10;

  // Control from the pipeline to the accumulator
  typedef struct packed {
    logic load;     // item leaves stage 1 into the output register
    logic filled;   // ring entry read for this item holds a real scan
  } boxavg_ctl_t;

endpackage

/* rtl/boxavg_ring_ram.sv */
// ----------------------------------------------------------------------------
// boxavg_ring_ram
// Scan ring: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module boxavg_ring_ram #(
  parameter int ADDR_BITS = 4,
  parameter int DATA_BITS = 80
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold the read data while the reading item stalls
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/boxavg_accum.sv */
// ----------------------------------------------------------------------------
// boxavg_accum
// Per-channel running sums and the registered window means.
// ----------------------------------------------------------------------------
module boxavg_accum #(
  parameter int WINDOW_LOG2 = 4,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                                                       clk,
  input  logic                                                       rst,
  input  boxavg_pkg::boxavg_ctl_t                                    ctl,
  input  logic [boxavg_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0]             fresh,
  input  logic [boxavg_pkg::NUM_CH-1:0][SAMPLE_BITS-1:0]             stale,
  output logic [boxavg_pkg::NUM_CH-1:0][boxavg_pkg::FIELD_BITS-1:0]  mean
);

  localparam int SUM_BITS = WINDOW_LOG2 + SAMPLE_BITS;

  logic [boxavg_pkg::NUM_CH-1:0][SUM_BITS-1:0] sums;
  logic [boxavg_pkg::NUM_CH-1:0][SUM_BITS-1:0] sums_next;

  always_comb begin
    for (int c = 0; c < boxavg_pkg::NUM_CH; c++) begin
      // unwritten entries count as zero until the ring has wrapped once
      sums_next[c] = sums[c] + SUM_BITS'(fresh[c])
                     - (ctl.filled ? SUM_BITS'(stale[c]) : SUM_BITS'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sums <= '0;
    end else if (ctl.load) begin
      sums <= sums_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int c = 0; c < boxavg_pkg::NUM_CH; c++) begin
        mean[c] <= boxavg_pkg::FIELD_BITS'(sums_next[c] >> WINDOW_LOG2);
      end
    end
  end

endmodule

/* rtl/multichannel_boxcar_average_core.sv */
// ----------------------------------------------------------------------------
// multichannel_boxcar_average_core
// Eight-channel moving average over the last 2^WINDOW_LOG2 scans.
//
//   channel  handshake             payload
//   input    in_valid / in_ready   sample_ch0 .. sample_ch7
//   output   out_valid / out_ready mean_ch0 .. mean_ch7, window_full
//
// One item per cycle sustained while the output does not stall. Each item
// reads its ring entry at the accepting edge, then its sum update goes into
// the output register, where the result is presented.
// The ring address advances by one per item, so the read of the next entry
// never meets the write of the previous one.
// Reset clears the sums, the write position and the first-wrap flag; ring entries
// not yet written are ignored until the first wrap, so no clearing pass.
// A stalled output holds the pipeline; the input is taken whenever stage 1
// is empty or moves on.
// ----------------------------------------------------------------------------
module multichannel_boxcar_average_core #(
  parameter int WINDOW_LOG2 = 4,
  parameter int SAMPLE_BITS = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [boxavg_pkg::FIELD_BITS-1:0] sample_ch0,
  input  logic [boxavg_pkg::FIELD_BITS-1:0] sample_ch1,
  input  logic [boxavg_pkg::FIELD_BITS-1:0] sample_ch2,
  input  logic [boxavg_pkg::FIELD_BITS-1:0] sample_ch3,
  input  logic [boxavg_pkg::FIELD_BITS-1:0] sample_ch4,
  input  logic [boxavg_pkg::FIELD_BITS-1:0] sample_ch5,
  input  logic [boxavg_pkg::FIELD_BITS-1:0] sample_ch6,
  input  logic [boxavg_pkg::FIELD_BITS-1:0] sample_ch7,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [boxavg_pkg::FIELD_BITS-1:0] mean_ch0,
  output logic [boxavg_pkg::FIELD_BITS-1:0] mean_ch1,
  output logic [boxavg_pkg::FIELD_BITS-1:0] mean_ch2,
  output logic [boxavg_pkg::FIELD_BITS-1:0] mean_ch3,
  output logic [boxavg_pkg::FIELD_BITS-1:0] mean_ch4,
  output logic [boxavg_pkg::FIELD_BITS-1:0] mean_ch5,
  output logic [boxavg_pkg::FIELD_BITS-1:0] mean_ch6,
  output logic [boxavg_pkg::FIELD_BITS-1:0] mean_ch7,
  output logic                             window_full
);

  localparam int NCH       = boxavg_pkg::NUM_CH;
  localparam int SCAN_BITS = NCH * SAMPLE_BITS;

  logic                               in_acc;
  logic                               s1_adv;
  logic [WINDOW_LOG2-1:0]             pos;
  logic                               filled;
  logic                               s1_valid;
  logic [WINDOW_LOG2-1:0]             s1_pos;
  logic                               s1_filled;
  logic [NCH-1:0][SAMPLE_BITS-1:0]    fresh;
  logic [NCH-1:0][SAMPLE_BITS-1:0]    s1_samples;
  logic [SCAN_BITS-1:0]               rd_data;
  logic [NCH-1:0][boxavg_pkg::FIELD_BITS-1:0] mean;
  boxavg_pkg::boxavg_ctl_t            ctl;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // drop sample bits above SAMPLE_BITS, or zero-extend
  assign fresh[0] = SAMPLE_BITS'(sample_ch0);
  assign fresh[1] = SAMPLE_BITS'(sample_ch1);
  assign fresh[2] = SAMPLE_BITS'(sample_ch2);
  assign fresh[3] = SAMPLE_BITS'(sample_ch3);
  assign fresh[4] = SAMPLE_BITS'(sample_ch4);
  assign fresh[5] = SAMPLE_BITS'(sample_ch5);
  assign fresh[6] = SAMPLE_BITS'(sample_ch6);
  assign fresh[7] = SAMPLE_BITS'(sample_ch7);

  // write position and first-wrap flag advance at accept
  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      filled <= 1'b0;
    end else if (in_acc) begin
      pos <= pos + WINDOW_LOG2'(1);
      if (pos == {WINDOW_LOG2{1'b1}}) begin
        filled <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pos     <= pos;
      s1_filled  <= filled;
      s1_samples <= fresh;
    end
  end

  boxavg_ring_ram #(
    .ADDR_BITS (WINDOW_LOG2),
    .DATA_BITS (SCAN_BITS)
  ) u_ring (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (pos),
    .rd_data (rd_data),
    .wr_en   (s1_adv),
    .wr_addr (s1_pos),
    .wr_data (s1_samples)
  );

  assign ctl.load   = s1_adv;
  assign ctl.filled = s1_filled;

  boxavg_accum #(
    .WINDOW_LOG2 (WINDOW_LOG2),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_accum (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .fresh (s1_samples),
    .stale (rd_data),
    .mean  (mean)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  // flag as it stands after this item's scan
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      window_full <= s1_filled || (s1_pos == {WINDOW_LOG2{1'b1}});
    end
  end

  assign mean_ch0 = mean[0];
  assign mean_ch1 = mean[1];
  assign mean_ch2 = mean[2];
  assign mean_ch3 = mean[3];
  assign mean_ch4 = mean[4];
  assign mean_ch5 = mean[5];
  assign mean_ch6 = mean[6];
  assign mean_ch7 = mean[7];

endmodule
